// ===== rtl/gcp_pkg.sv =====
// Shared types and constants of the coordinate parser.
`timescale 1ns / 1ps
package gcp_pkg;

	localparam int FRACTION_DIGITS_DEF = 6;

	// exponent field covers scale steps up to FRACTION_DIGITS + 6 (at most 15)
	localparam int EXP_W = 4;
	localparam int MAG_W = 63;
	localparam int LINE_W = 24;

	localparam logic [MAG_W-1:0] NEG_LIMIT = 63'h4000_0000_0000_0000;
	localparam logic [MAG_W-1:0] POS_LIMIT = NEG_LIMIT - 63'd1;
	localparam logic [MAG_W-1:0] MAG_CAP   = NEG_LIMIT + 63'd1;

	localparam int POW_W = 14;
	localparam logic [POW_W-1:0] POW10 [5] = '{
		14'd1, 14'd10, 14'd100, 14'd1000, 14'd10000
	};
	// largest magnitude that stays within NEG_LIMIT after scaling by POW10[k]
	localparam logic [MAG_W-1:0] SCALE_THR [5] = '{
		NEG_LIMIT,
		NEG_LIMIT / 63'd10,
		NEG_LIMIT / 63'd100,
		NEG_LIMIT / 63'd1000,
		NEG_LIMIT / 63'd10000
	};

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_DIGITS = 2'd1,
		ST_END       = 2'd2,
		ST_SAT       = 2'd3
	} status_t;

	localparam logic [1:0] REG_INT_DIGITS = 2'd0;
	localparam logic [1:0] REG_DEC_DIGITS = 2'd1;
	localparam logic [1:0] REG_OMIT       = 2'd2;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [MAG_W-1:0]  mag;
		logic              over;
		logic              neg;
		status_t           status;
		logic [EXP_W-1:0]  expo;
		logic [7:0]        term;
		logic [LINE_W-1:0] line;
	} gcp_item_t;

endpackage

// ===== rtl/gerber_coordinate_parser.sv =====
// Coordinate parser top level: byte stream in, one parsed coordinate per number out.
//
// Input stream: one text byte per request in s_tdata[7:0]; s_tuser high marks end of
// data (s_tdata ignored). Whitespace is skipped, LF counts lines, digits with an
// optional sign and '.' build a number, and any other byte ends it.
// Output stream: one request per finished number with coordinate (units of
// 10^-FRACTION_DIGITS), terminator byte and line count in m_tdata, status in m_tuser.
// An end-of-data request always gives a result with status END.
// Throughput: one byte per cycle unless a terminator finds the stage chain full. Each
// byte is registered, parsed against the number state, then the result walks through
// 1 + (FRACTION_DIGITS+6)/4 scaling stages (multiply by 10^k with overflow check) and
// the output register.
// When the receiver stalls, results wait in the stage registers; the input keeps
// taking bytes until a terminator finds the stage chain full.
// Configuration: APB registers integer_digits (0x0), decimal_digits (0x4) and
// omit_trailing (0x8); write them only while the stream is idle.
// Reset clears the number state, the line count and all valid flags, and loads the
// format registers with 2, 4 and 0. pready is tied high.
`timescale 1ns / 1ps
module gerber_coordinate_parser #(
	parameter int FRACTION_DIGITS = gcp_pkg::FRACTION_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] end_of_data
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [62:0] coordinate, [70:63] terminator, [94:71] line_index
	output logic [1:0]  m_tuser,   // [1:0] status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gcp_pkg::*;

	localparam int FCW = $clog2(FRACTION_DIGITS + 1);
	localparam int N4  = (FRACTION_DIGITS + 6) / 4;

	typedef enum logic [1:0] {
		PH_SIGN = 2'd0,
		PH_INT  = 2'd1,
		PH_FRAC = 2'd2
	} phase_t;

	// configuration
	logic [2:0] int_digits_q;
	logic [2:0] dec_digits_q;
	logic       omit_q;
	logic       cfg_wr;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eod_s1;

	// number state
	phase_t            phase_q;
	logic              neg_q;
	logic [MAG_W-1:0]  acc_q;
	logic [MAG_W-1:0]  prev_q;
	logic [4:0]        dig_cnt_q;
	logic [FCW-1:0]    frac_cnt_q;
	logic [LINE_W-1:0] line_cnt_q;

	// parse decode
	logic             is_digit;
	logic             is_space;
	logic             take_digit;
	logic             fire;
	logic             consume;
	logic [3:0]       digit;
	logic [MAG_W+2:0] ttp_sum;
	logic [MAG_W-1:0] ttp;
	logic signed [7:0] e_full;
	logic signed [7:0] pad;
	logic             no_digits;

	// scaling chain: index 0 is the parse result
	gcp_item_t st_item  [N4+2];
	logic      st_valid [N4+2];
	logic      st_ready [N4+2];

	// output stage
	gcp_item_t        fin;
	logic             fin_sat;
	logic [MAG_W-1:0] fin_mag;
	logic             out_valid_q;
	logic [MAG_W-1:0] out_coord_q;
	logic [7:0]       out_term_q;
	logic [LINE_W-1:0] out_line_q;
	status_t          out_status_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_digits_q <= 3'd2;
			dec_digits_q <= 3'd4;
			omit_q       <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_INT_DIGITS: int_digits_q <= pwdata[2:0];
				REG_DEC_DIGITS: dec_digits_q <= pwdata[2:0];
				REG_OMIT:       omit_q       <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_INT_DIGITS: prdata = {29'd0, int_digits_q};
			REG_DEC_DIGITS: prdata = {29'd0, dec_digits_q};
			REG_OMIT:       prdata = {31'd0, omit_q};
			default:        prdata = 32'd0;
		endcase
	end

	// ---------------- input register ----------------
	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eod_s1  <= s_tuser;
		end
	end

	// ---------------- parse ----------------
	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign is_space = (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB) || (byte_s1 == CH_CR);
	assign digit    = 4'(byte_s1 - CH_ZERO);

	// saturating acc * 10 + digit
	assign ttp_sum = ((MAG_W+3)'(acc_q) << 3) + ((MAG_W+3)'(acc_q) << 1) + (MAG_W+3)'(digit);
	assign ttp     = (ttp_sum > (MAG_W+3)'(MAG_CAP)) ? MAG_CAP : ttp_sum[MAG_W-1:0];

	assign take_digit = is_digit &&
		((phase_q != PH_FRAC) || (frac_cnt_q < FCW'(FRACTION_DIGITS)));

	always_comb begin
		fire = 1'b0;
		if (eod_s1) begin
			fire = 1'b1;
		end else if (byte_s1 == CH_LF || is_space || is_digit) begin
			fire = 1'b0;
		end else if (phase_q == PH_SIGN && (byte_s1 == CH_MINUS || byte_s1 == CH_PLUS)) begin
			fire = 1'b0;
		end else if (phase_q != PH_FRAC && byte_s1 == CH_DOT) begin
			fire = 1'b0;
		end else begin
			fire = 1'b1;
		end
	end

	assign consume = valid_s1 && (!fire || st_ready[0]);

	// decimal exponent applied to the accumulated digits
	always_comb begin
		pad = 8'(int_digits_q) + 8'(dec_digits_q) - 8'(dig_cnt_q);
		if (phase_q == PH_FRAC) begin
			e_full = 8'(FRACTION_DIGITS) - 8'(frac_cnt_q);
		end else begin
			e_full = 8'(FRACTION_DIGITS) - 8'(dec_digits_q);
			if (omit_q && pad > 8'sd0) begin
				e_full = e_full + pad;
			end
		end
	end

	assign no_digits = (dig_cnt_q == 5'd0) && (frac_cnt_q == '0);

	always_comb begin
		st_item[0].over   = 1'b0;
		st_item[0].neg    = neg_q;
		st_item[0].line   = line_cnt_q;
		st_item[0].term   = byte_s1;
		st_item[0].mag    = acc_q;
		st_item[0].expo   = '0;
		st_item[0].status = ST_OK;
		if (eod_s1) begin
			st_item[0].term   = 8'd0;
			st_item[0].mag    = '0;
			st_item[0].status = ST_END;
		end else if (no_digits) begin
			st_item[0].mag    = '0;
			st_item[0].status = ST_NO_DIGITS;
		end else if (e_full[7]) begin
			// one place to the right: prev_q holds acc / 10 unless acc saturated
			if (acc_q != MAG_CAP) begin
				st_item[0].mag = prev_q;
			end
		end else begin
			st_item[0].expo = e_full[EXP_W-1:0];
		end
	end

	assign st_valid[0] = valid_s1 && fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SIGN;
			neg_q      <= 1'b0;
			acc_q      <= '0;
			dig_cnt_q  <= 5'd0;
			frac_cnt_q <= '0;
			line_cnt_q <= '0;
		end else if (consume) begin
			if (fire) begin
				phase_q    <= PH_SIGN;
				neg_q      <= 1'b0;
				acc_q      <= '0;
				dig_cnt_q  <= 5'd0;
				frac_cnt_q <= '0;
			end else if (byte_s1 == CH_LF) begin
				line_cnt_q <= line_cnt_q + LINE_W'(1);
			end else if (is_digit) begin
				if (take_digit) begin
					acc_q <= ttp;
				end
				if (phase_q == PH_FRAC) begin
					if (take_digit) begin
						frac_cnt_q <= frac_cnt_q + FCW'(1);
					end
				end else begin
					if (dig_cnt_q != 5'd31) begin
						dig_cnt_q <= dig_cnt_q + 5'd1;
					end
					phase_q <= PH_INT;
				end
			end else if (phase_q == PH_SIGN && (byte_s1 == CH_MINUS || byte_s1 == CH_PLUS)) begin
				neg_q   <= (byte_s1 == CH_MINUS);
				phase_q <= PH_INT;
			end else if (phase_q != PH_FRAC && byte_s1 == CH_DOT) begin
				phase_q <= PH_FRAC;
			end
		end
	end

	// value before the last digit, i.e. floor(acc / 10) while acc is below the cap
	always_ff @(posedge clk) begin
		if (consume && !fire && take_digit) begin
			prev_q <= acc_q;
		end
	end

	// ---------------- scaling chain ----------------
	for (genvar i = 0; i <= N4; i++) begin : g_scale
		gcp_scale_stage #(
			.STAGE(i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (st_valid[i]),
			.in_ready (st_ready[i]),
			.in_item  (st_item[i]),
			.out_valid(st_valid[i+1]),
			.out_ready(st_ready[i+1]),
			.out_item (st_item[i+1])
		);
	end

	// ---------------- bound check, sign and output register ----------------
	assign fin     = st_item[N4+1];
	assign fin_sat = (fin.status == ST_OK) &&
		(fin.over || (!fin.neg && fin.mag > POS_LIMIT) || (fin.neg && fin.mag > NEG_LIMIT));
	assign fin_mag = fin_sat ? (fin.neg ? NEG_LIMIT : POS_LIMIT) : fin.mag;

	assign st_ready[N4+1] = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_ready[N4+1]) begin
			out_valid_q <= st_valid[N4+1];
		end
	end

	always_ff @(posedge clk) begin
		if (st_ready[N4+1] && st_valid[N4+1]) begin
			out_coord_q  <= fin.neg ? (~fin_mag + MAG_W'(1)) : fin_mag;
			out_term_q   <= fin.term;
			out_line_q   <= fin.line;
			out_status_q <= fin_sat ? ST_SAT : fin.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_line_q, out_term_q, out_coord_q};
	assign m_tuser  = out_status_q;

endmodule

// ===== rtl/gcp_scale_stage.sv =====
// One decimal scaling stage of the result path, with overflow detection.
`timescale 1ns / 1ps
module gcp_scale_stage #(
	parameter int STAGE = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gcp_pkg::gcp_item_t in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output gcp_pkg::gcp_item_t out_item
);
	import gcp_pkg::*;

	logic [2:0]             fidx;
	logic [MAG_W+POW_W-1:0] prod;
	gcp_item_t              next_item;
	logic                   valid_q;
	gcp_item_t              item_q;

	// stage 0 takes the low two exponent bits, later stages one factor of 1e4 each
	always_comb begin
		if (STAGE == 0) begin
			fidx = {1'b0, in_item.expo[1:0]};
		end else if (in_item.expo[EXP_W-1:2] >= (EXP_W-2)'(STAGE)) begin
			fidx = 3'd4;
		end else begin
			fidx = 3'd0;
		end
	end

	assign prod = (MAG_W+POW_W)'(in_item.mag) * (MAG_W+POW_W)'(POW10[fidx]);

	always_comb begin
		next_item      = in_item;
		next_item.mag  = prod[MAG_W-1:0];
		next_item.over = in_item.over || (in_item.mag > SCALE_THR[fidx]);
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= next_item;
		end
	end

endmodule

// ===== rtl/gcp_checker.sv =====
// Port-level checks for the coordinate parser and their binding.
`timescale 1ns / 1ps
module gcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import gcp_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// end of data carries zero coordinate and zero terminator
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_END |-> m_tdata[70:0] == 71'd0)
		else $error("end-of-data result not cleared");

	// a number without digits reads as zero
	a_nodig_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_NO_DIGITS |-> m_tdata[62:0] == 63'd0)
		else $error("no-digit result not zero");

	// a saturated result sits on one of the two bounds
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_SAT |->
			m_tdata[62:0] == POS_LIMIT || m_tdata[62:0] == NEG_LIMIT)
		else $error("saturated result off bound");

	// the pad bit above the line count stays low
	a_pad_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[95])
		else $error("tdata pad bit set");

endmodule

bind gerber_coordinate_parser gcp_checker u_gcp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// ===== dv/tb_top.sv =====
// Testbench for the coordinate parser: directed table, random text, scoreboard check.
`timescale 1ns / 1ps
module tb_top;
	import gcp_pkg::*;

	localparam int FRAC = FRACTION_DIGITS_DEF;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 180;
	localparam logic [63:0] CAP64 = {1'b0, MAG_CAP};
	localparam logic [63:0] NEG64 = {1'b0, NEG_LIMIT};
	localparam logic [63:0] POS64 = {1'b0, POS_LIMIT};

	typedef enum logic [1:0] {
		PH_SIGN = 2'd0,
		PH_INT  = 2'd1,
		PH_FRAC = 2'd2
	} parse_phase_t;

	typedef struct packed {
		logic [62:0] coord;
		logic [7:0]  term;
		logic [23:0] line;
		status_t     st;
	} coord_rec_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eod;
		logic       pinned;
		coord_rec_t want;
	} text_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	gerber_coordinate_parser u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// format registers as the parser should hold them
	logic [2:0]   fmt_int = 3'd2;
	logic [2:0]   fmt_dec = 3'd4;
	logic         fmt_omit = 1'b0;
	// number state of the parser
	parse_phase_t num_phase = PH_SIGN;
	logic         num_neg = 1'b0;
	logic [63:0]  num_mag = 64'd0;
	logic [4:0]   int_cnt = 5'd0;
	logic [2:0]   frac_cnt = 3'd0;
	logic [23:0]  line_cnt = 24'd0;

	coord_rec_t coord_q [$];
	int errors = 0;
	int items_sent = 0;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;

	logic [7:0] ws_set [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
	logic [7:0] term_set [6] = '{"X", "Y", "D", "*", "I", "J"};

	int cfg_int [PHASES]  = '{2, 2, 7, 1, 3, 7, 0, 4, 6};
	int cfg_dec [PHASES]  = '{4, 4, 6, 0, 5, 7, 0, 3, 6};
	int cfg_omit [PHASES] = '{0, 1, 1, 0, 1, 0, 1, 0, 1};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	function automatic logic [63:0] times_ten_add(input logic [63:0] a, input logic [63:0] d);
		if (a >= CAP64 || a > (CAP64 - d) / 10)
			return CAP64;
		return a * 10 + d;
	endfunction

	function automatic void clear_number();
		num_phase = PH_SIGN;
		num_neg = 1'b0;
		num_mag = 64'd0;
		int_cnt = 5'd0;
		frac_cnt = 3'd0;
	endfunction

	// advance the parser by one byte; returns 1 when a coordinate comes out
	function automatic bit parse_byte(input logic [7:0] c, input logic eod,
			output coord_rec_t r);
		logic [63:0] m;
		int e;
		int pad;
		r = '0;
		if (eod) begin
			r.line = line_cnt;
			r.st = ST_END;
			clear_number();
			return 1'b1;
		end
		if (c == CH_LF) begin
			line_cnt = line_cnt + 24'd1;
			return 1'b0;
		end
		if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
			return 1'b0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (num_phase == PH_FRAC) begin
				if (frac_cnt < FRAC) begin
					num_mag = times_ten_add(num_mag, 64'(c - CH_ZERO));
					frac_cnt = frac_cnt + 3'd1;
				end
			end else begin
				num_mag = times_ten_add(num_mag, 64'(c - CH_ZERO));
				if (int_cnt < 5'd31)
					int_cnt = int_cnt + 5'd1;
				num_phase = PH_INT;
			end
			return 1'b0;
		end
		if (num_phase == PH_SIGN && (c == CH_MINUS || c == CH_PLUS)) begin
			num_neg = (c == CH_MINUS);
			num_phase = PH_INT;
			return 1'b0;
		end
		if (num_phase != PH_FRAC && c == CH_DOT) begin
			num_phase = PH_FRAC;
			return 1'b0;
		end
		// anything else ends the number
		m = num_mag;
		r.st = ST_OK;
		if (int_cnt == 0 && frac_cnt == 0) begin
			r.st = ST_NO_DIGITS;
			m = 64'd0;
		end else begin
			if (num_phase == PH_FRAC) begin
				e = FRAC - int'(frac_cnt);
			end else begin
				e = FRAC - int'(fmt_dec);
				if (fmt_omit) begin
					pad = int'(fmt_int) + int'(fmt_dec) - int'(int_cnt);
					if (pad > 0)
						e = e + pad;
				end
			end
			for (int k = 0; k < e; k++)
				m = times_ten_add(m, 64'd0);
			if (m < CAP64)
				for (int k = 0; k < -e; k++)
					m = m / 10;
			if (num_neg ? (m > NEG64) : (m > POS64)) begin
				r.st = ST_SAT;
				m = num_neg ? NEG64 : POS64;
			end
		end
		r.coord = num_neg ? 63'(~m + 64'd1) : m[62:0];
		r.term = c;
		r.line = line_cnt;
		clear_number();
		return 1'b1;
	endfunction

	always @(posedge clk) begin : check_results
		coord_rec_t want;
		coord_rec_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.coord = m_tdata[62:0];
			got.term = m_tdata[70:63];
			got.line = m_tdata[94:71];
			got.st = status_t'(m_tuser);
			if (coord_q.size() == 0) begin
				if (errors < 10)
					$display("%0t unexpected result coord=%0d term=%h line=%0d st=%0d",
						$realtime, $signed(got.coord), got.term, got.line, got.st);
				errors++;
			end else begin
				want = coord_q.pop_front();
				if (got.coord !== want.coord || got.term !== want.term ||
						got.line !== want.line || got.st !== want.st) begin
					if (errors < 10)
						$display("%0t mismatch: exp %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
							$realtime, $signed(want.coord), want.term, want.line, want.st,
							$signed(got.coord), got.term, got.line, got.st);
					errors++;
				end
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic eod);
		coord_rec_t r;
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= eod;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (parse_byte(b, eod, r))
			coord_q = {coord_q, r};
		items_sent++;
	endtask

	// hold the stream idle until every coordinate is out, then let the pipe settle
	task automatic drain_stream();
		s_tvalid <= 1'b0;
		while (coord_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
		logic [31:0] kept;
		logic [31:0] keep_mask;
		keep_mask = (idx == REG_OMIT) ? 32'h1 : 32'h7;
		kept = {29'd0, val} & keep_mask;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom() & ~keep_mask) | kept;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		// read back right after the write
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== kept) begin
			if (errors < 10)
				$display("%0t register %0d read exp %h got %h", $realtime, idx, kept, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_INT_DIGITS: fmt_int = kept[2:0];
			REG_DEC_DIGITS: fmt_dec = kept[2:0];
			REG_OMIT:       fmt_omit = kept[0];
			default: ;
		endcase
	endtask

	task automatic send_digits(input int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(19) == 0)
				push_byte(ws_set[$urandom_range(3)], 1'b0);
			// lean toward zeroes now and then so padding and trailing zeroes show up
			if ($urandom_range(3) == 0)
				push_byte(CH_ZERO, 1'b0);
			else
				push_byte(CH_ZERO + 8'($urandom_range(9)), 1'b0);
		end
	endtask

	// one number with random content, noise or an end-of-data request
	task automatic send_token();
		int r;
		int n_int;
		r = $urandom_range(99);
		if (r < 8) begin
			push_byte(8'($urandom_range(255)), 1'b0);
			return;
		end
		if (r < 11) begin
			push_byte(8'($urandom_range(255)), 1'b1);
			return;
		end
		if ($urandom_range(3) == 0)
			push_byte(ws_set[$urandom_range(3)], 1'b0);
		r = $urandom_range(9);
		if (r < 3)
			push_byte(CH_MINUS, 1'b0);
		else if (r < 5)
			push_byte(CH_PLUS, 1'b0);
		n_int = ($urandom_range(9) == 0) ? $urandom_range(14, 25) : $urandom_range(0, 8);
		send_digits(n_int);
		if ($urandom_range(9) < 4) begin
			push_byte(CH_DOT, 1'b0);
			send_digits($urandom_range(0, 9));
		end
		r = $urandom_range(9);
		if (r < 7)
			push_byte(term_set[$urandom_range(5)], 1'b0);
		else if (r < 8)
			push_byte(($urandom_range(1) != 0) ? CH_MINUS : CH_DOT, 1'b0);
		else
			push_byte(8'($urandom_range(255)), 1'b0);
	endtask

	initial begin : run_stimulus
		text_row_t dir_rows [$];
		int phase_goal;
		dir_rows = '{
			'{8'h00,    1'b1, 1'b1, '{63'd0, 8'h00, 24'd0, ST_END}},
			'{"*",      1'b0, 1'b1, '{63'd0, "*", 24'd0, ST_NO_DIGITS}},
			'{CH_LF,    1'b0, 1'b0, '0},
			'{CH_MINUS, 1'b0, 1'b0, '0},
			'{"X",      1'b0, 1'b1, '{63'd0, "X", 24'd1, ST_NO_DIGITS}},
			'{CH_DOT,   1'b0, 1'b0, '0},
			'{"Y",      1'b0, 1'b1, '{63'd0, "Y", 24'd1, ST_NO_DIGITS}},
			'{CH_PLUS,  1'b0, 1'b0, '0},
			'{CH_NINE,  1'b0, 1'b0, '0},
			'{CH_MINUS, 1'b0, 1'b0, '0},
			'{CH_MINUS, 1'b0, 1'b0, '0},
			'{CH_MINUS, 1'b0, 1'b0, '0},
			'{CH_SPACE, 1'b0, 1'b0, '0},
			'{"1",      1'b0, 1'b0, '0},
			'{CH_TAB,   1'b0, 1'b0, '0},
			'{CH_DOT,   1'b0, 1'b0, '0},
			'{CH_CR,    1'b0, 1'b0, '0},
			'{"5",      1'b0, 1'b0, '0},
			'{CH_DOT,   1'b0, 1'b0, '0},
			'{CH_ZERO,  1'b0, 1'b0, '0},
			'{CH_ZERO,  1'b0, 1'b0, '0},
			'{8'hFF,    1'b0, 1'b0, '0},
			'{"7",      1'b0, 1'b0, '0},
			'{8'hFF,    1'b1, 1'b1, '{63'd0, 8'h00, 24'd1, ST_END}}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			push_byte(dir_rows[i].data, dir_rows[i].eod);
			// rows with a hand-written result replace the predicted one
			if (dir_rows[i].pinned)
				coord_q[coord_q.size() - 1] = dir_rows[i].want;
		end
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain_stream();
				write_reg(REG_INT_DIGITS, 3'(cfg_int[ph]));
				write_reg(REG_DEC_DIGITS, 3'(cfg_dec[ph]));
				write_reg(REG_OMIT, 3'(cfg_omit[ph]));
			end
			case (ph % 4)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 67; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 67; end
				default: begin snd_idle_pct = 25; rcv_stall_pct = 25; end
			endcase
			phase_goal = items_sent + ITEMS_PER_PHASE;
			while (items_sent < phase_goal)
				send_token();
			// close any number still open before the format changes
			push_byte("*", 1'b0);
		end
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		drain_stream();
		if (errors == 0 && coord_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
